// File: hdl/lbr_pkg.sv
// Shared types and codes for the Bresenham line raster unit.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps

package lbr_pkg;

  // Default coordinate width of the unit.
  localparam int unsigned COORD_BITS_DEF = 10;

  // Item kinds carried on the input tuser bit.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Octant description of the line being drawn.
  typedef struct packed {
    logic ymaj;   // y is the major axis
    logic yneg;   // y moves toward smaller values
    logic xneg;   // x moves toward smaller values
  } dir_t;

endpackage

// File: hdl/lbr_setup.sv
// Line setup: octant, absolute deltas and initial decision value from two endpoints.
// Depends on lbr_pkg.
`timescale 1ns / 1ps

module lbr_setup #(
  parameter int unsigned COORD_BITS = lbr_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]   start_x_i,
  input  logic [COORD_BITS-1:0]   start_y_i,
  input  logic [COORD_BITS-1:0]   end_x_i,
  input  logic [COORD_BITS-1:0]   end_y_i,
  output logic [COORD_BITS-1:0]   abs_dx_o,
  output logic [COORD_BITS-1:0]   abs_dy_o,
  output logic [COORD_BITS+2:0]   decision_o,
  output lbr_pkg::dir_t           dir_o,
  output logic                    busy_o
);

  logic [COORD_BITS-1:0] maj;
  logic [COORD_BITS-1:0] mnr;

  always_comb begin
    dir_o.xneg = end_x_i < start_x_i;
    dir_o.yneg = end_y_i < start_y_i;
    abs_dx_o   = dir_o.xneg ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
    abs_dy_o   = dir_o.yneg ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
    // Equal deltas keep x as the major axis.
    dir_o.ymaj = abs_dy_o > abs_dx_o;
    maj        = dir_o.ymaj ? abs_dy_o : abs_dx_o;
    mnr        = dir_o.ymaj ? abs_dx_o : abs_dy_o;
    decision_o = {2'b00, mnr, 1'b0} - {3'b000, maj};
    busy_o     = (start_x_i != end_x_i) || (start_y_i != end_y_i);
  end

endmodule

// File: hdl/lbr_step.sv
// One Bresenham step: next pixel, next decision value and endpoint detection.
// Depends on lbr_pkg.
`timescale 1ns / 1ps

module lbr_step #(
  parameter int unsigned COORD_BITS = lbr_pkg::COORD_BITS_DEF
) (
  input  logic [COORD_BITS-1:0]   cur_x_i,
  input  logic [COORD_BITS-1:0]   cur_y_i,
  input  logic [COORD_BITS-1:0]   target_x_i,
  input  logic [COORD_BITS-1:0]   target_y_i,
  input  logic [COORD_BITS-1:0]   abs_dx_i,
  input  logic [COORD_BITS-1:0]   abs_dy_i,
  input  logic [COORD_BITS+2:0]   decision_i,
  input  lbr_pkg::dir_t           dir_i,
  output logic [COORD_BITS-1:0]   next_x_o,
  output logic [COORD_BITS-1:0]   next_y_o,
  output logic [COORD_BITS+2:0]   decision_o,
  output logic                    done_o
);

  logic [COORD_BITS-1:0] maj;
  logic [COORD_BITS-1:0] mnr;
  logic [COORD_BITS-1:0] step_x;
  logic [COORD_BITS-1:0] step_y;
  logic                  move_minor;

  always_comb begin
    maj        = dir_i.ymaj ? abs_dy_i : abs_dx_i;
    mnr        = dir_i.ymaj ? abs_dx_i : abs_dy_i;
    // The minor axis moves only on a strictly positive decision value.
    move_minor = !decision_i[COORD_BITS+2] && (decision_i != '0);
    step_x     = dir_i.xneg ? (cur_x_i - COORD_BITS'(1)) : (cur_x_i + COORD_BITS'(1));
    step_y     = dir_i.yneg ? (cur_y_i - COORD_BITS'(1)) : (cur_y_i + COORD_BITS'(1));
    if (dir_i.ymaj) begin
      next_y_o = step_y;
      next_x_o = move_minor ? step_x : cur_x_i;
      done_o   = step_y == target_y_i;
    end else begin
      next_x_o = step_x;
      next_y_o = move_minor ? step_y : cur_y_i;
      done_o   = step_x == target_x_i;
    end
    if (move_minor) begin
      decision_o = decision_i + ({2'b00, mnr, 1'b0} - {2'b00, maj, 1'b0});
    end else begin
      decision_o = decision_i + {2'b00, mnr, 1'b0};
    end
  end

endmodule

// File: hdl/line_bresenham_raster_unit.sv
// Top level of the Bresenham line raster unit: input register, line state, result register.
// Depends on lbr_pkg, lbr_setup and lbr_step.
`timescale 1ns / 1ps

// Channel   Direction  Payload (lowest bit first)
// s_axis    in         tdata: start_x, start_y, end_x, end_y; tuser: func
// m_axis    out        tdata: pixel_x, pixel_y; tuser: valid_res; tlast: last
//
// One item is accepted per clock unless m_axis stalls; every item gives exactly one result.
// A result is presented from the result register: the item waits in the input
// register, then the setup or step logic writes the line state and the result
// register in the same edge. The loop through the decision register is a single
// add, which sets the one-pixel-per-clock rate while m_axis is not stalled.
// Reset clears the line state to idle and empties both registers. A stall on
// m_axis holds the result; the input register still takes one more item.
module line_bresenham_raster_unit #(
  parameter int unsigned COORD_BITS = lbr_pkg::COORD_BITS_DEF,
  localparam int unsigned IN_W      = ((4 * COORD_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((2 * COORD_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // start_x, start_y, end_x, end_y from the lowest bit up
  input  logic [IN_W-1:0]       s_axis_tdata_i,
  // func: load or step
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // pixel_x, pixel_y from the lowest bit up, zero padded
  output logic [OUT_W-1:0]      m_axis_tdata_o,
  // valid_res
  output logic                  m_axis_tuser_o,
  // last pixel of the line
  output logic                  m_axis_tlast_o
);

  localparam int unsigned DW    = COORD_BITS + 3;

  // Input register.
  logic                  in_valid_q, in_valid_d;
  logic                  in_func_q;
  logic [4*COORD_BITS-1:0] in_data_q;
  logic                  s_xfer;
  logic                  fire;

  // Line state.
  logic [COORD_BITS-1:0] cur_x_q, cur_x_d;
  logic [COORD_BITS-1:0] cur_y_q, cur_y_d;
  logic [COORD_BITS-1:0] target_x_q, target_x_d;
  logic [COORD_BITS-1:0] target_y_q, target_y_d;
  logic [COORD_BITS-1:0] abs_dx_q, abs_dx_d;
  logic [COORD_BITS-1:0] abs_dy_q, abs_dy_d;
  logic [DW-1:0]         decision_q, decision_d;
  lbr_pkg::dir_t         dir_q, dir_d;
  logic                  busy_q, busy_d;

  // Result register.
  logic                  out_valid_q, out_valid_d;
  logic [COORD_BITS-1:0] out_x_q, out_x_d;
  logic [COORD_BITS-1:0] out_y_q, out_y_d;
  logic                  out_res_q, out_res_d;
  logic                  out_last_q, out_last_d;

  // Setup and step results.
  logic [COORD_BITS-1:0] ld_start_x, ld_start_y, ld_end_x, ld_end_y;
  logic [COORD_BITS-1:0] su_abs_dx, su_abs_dy;
  logic [DW-1:0]         su_decision;
  lbr_pkg::dir_t         su_dir;
  logic                  su_busy;
  logic [COORD_BITS-1:0] st_x, st_y;
  logic [DW-1:0]         st_decision;
  logic                  st_done;

  assign ld_start_x = in_data_q[0*COORD_BITS +: COORD_BITS];
  assign ld_start_y = in_data_q[1*COORD_BITS +: COORD_BITS];
  assign ld_end_x   = in_data_q[2*COORD_BITS +: COORD_BITS];
  assign ld_end_y   = in_data_q[3*COORD_BITS +: COORD_BITS];

  lbr_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .start_x_i  (ld_start_x),
    .start_y_i  (ld_start_y),
    .end_x_i    (ld_end_x),
    .end_y_i    (ld_end_y),
    .abs_dx_o   (su_abs_dx),
    .abs_dy_o   (su_abs_dy),
    .decision_o (su_decision),
    .dir_o      (su_dir),
    .busy_o     (su_busy)
  );

  lbr_step #(
    .COORD_BITS (COORD_BITS)
  ) u_step (
    .cur_x_i    (cur_x_q),
    .cur_y_i    (cur_y_q),
    .target_x_i (target_x_q),
    .target_y_i (target_y_q),
    .abs_dx_i   (abs_dx_q),
    .abs_dy_i   (abs_dy_q),
    .decision_i (decision_q),
    .dir_i      (dir_q),
    .next_x_o   (st_x),
    .next_y_o   (st_y),
    .decision_o (st_decision),
    .done_o     (st_done)
  );

  // The held item moves on when the result register is empty or being drained.
  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign s_xfer          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_valid_d  = s_xfer ? 1'b1 : (fire ? 1'b0 : in_valid_q);
    out_valid_d = fire ? 1'b1 : (m_axis_tready_i ? 1'b0 : out_valid_q);

    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    target_x_d = target_x_q;
    target_y_d = target_y_q;
    abs_dx_d   = abs_dx_q;
    abs_dy_d   = abs_dy_q;
    decision_d = decision_q;
    dir_d      = dir_q;
    busy_d     = busy_q;
    out_x_d    = out_x_q;
    out_y_d    = out_y_q;
    out_res_d  = out_res_q;
    out_last_d = out_last_q;

    if (fire) begin
      if (in_func_q == lbr_pkg::FUNC_LOAD) begin
        // A load abandons any line in progress and returns the start pixel.
        cur_x_d    = ld_start_x;
        cur_y_d    = ld_start_y;
        target_x_d = ld_end_x;
        target_y_d = ld_end_y;
        abs_dx_d   = su_abs_dx;
        abs_dy_d   = su_abs_dy;
        decision_d = su_decision;
        dir_d      = su_dir;
        busy_d     = su_busy;
        out_x_d    = ld_start_x;
        out_y_d    = ld_start_y;
        out_res_d  = 1'b1;
        out_last_d = !su_busy;
      end else if (busy_q) begin
        cur_x_d    = st_x;
        cur_y_d    = st_y;
        decision_d = st_decision;
        busy_d     = !st_done;
        out_x_d    = st_x;
        out_y_d    = st_y;
        out_res_d  = 1'b1;
        out_last_d = st_done;
      end else begin
        // A step with no line in progress returns an empty result.
        out_x_d    = '0;
        out_y_d    = '0;
        out_res_d  = 1'b0;
        out_last_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      target_x_q  <= '0;
      target_y_q  <= '0;
      abs_dx_q    <= '0;
      abs_dy_q    <= '0;
      decision_q  <= '0;
      dir_q       <= '0;
      busy_q      <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      cur_x_q     <= cur_x_d;
      cur_y_q     <= cur_y_d;
      target_x_q  <= target_x_d;
      target_y_q  <= target_y_d;
      abs_dx_q    <= abs_dx_d;
      abs_dy_q    <= abs_dy_d;
      decision_q  <= decision_d;
      dir_q       <= dir_d;
      busy_q      <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_func_q <= s_axis_tuser_i;
      in_data_q <= s_axis_tdata_i[4*COORD_BITS-1:0];
    end
    out_x_q    <= out_x_d;
    out_y_q    <= out_y_d;
    out_res_q  <= out_res_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_y_q, out_x_q});
  assign m_axis_tuser_o  = out_res_q;
  assign m_axis_tlast_o  = out_last_q;

  // A result that ends a line leaves the unit idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && out_last_d |=> !busy_q)
    else $error("line end reported but unit still busy");

  // An empty result carries no pixel and no end mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_res_q |-> !out_last_q && out_x_q == '0 && out_y_q == '0)
    else $error("empty result carries pixel data");

  // A line in progress always has a nonzero major delta.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (dir_q.ymaj ? abs_dy_q : abs_dx_q) != '0)
    else $error("busy with zero major delta");

  // An empty input register always takes a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready_o)
    else $error("input register empty but not ready");

endmodule
